/* sv/atu_pkg.sv */
package atu_pkg;

  localparam int unsigned DataW     = 16;
  localparam int unsigned FracW     = 8;
  localparam int unsigned DividendW = DataW + FracW;
  localparam int unsigned SumW      = DividendW + 2;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [CfgIdxW-1:0] RegIncreaseStep = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDecreaseStep = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegUpperLimit   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegLowerLimit   = CfgIdxW'(3);

  localparam logic [DataW-1:0] IncreaseStepRst = 16'h0100;
  localparam logic [DataW-1:0] DecreaseStepRst = 16'h000d;
  localparam logic [DataW-1:0] UpperLimitRst   = 16'hc800;
  localparam logic [DataW-1:0] LowerLimitRst   = 16'h0200;

  // payload carried along the divider chain
  typedef struct packed {
    logic [DataW-1:0]     thr;
    logic                 fired;
    logic                 zero;
    logic [DataW-1:0]     div;
    logic [DataW-1:0]     rem;
    logic [DividendW-1:0] dq;   // dividend bits shift out on top, quotient bits in below
  } div_data_t;

  typedef struct packed {
    logic [DataW-1:0] upper;
    logic [DataW-1:0] lower;
  } limits_t;

endpackage

/* sv/atu_div_cell.sv */
module atu_div_cell import atu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_data_t data_i,
  output logic      valid_o,
  output div_data_t data_o
);

  logic      valid_q;
  div_data_t data_q, data_d;
  logic [DataW:0] trial;
  logic [DataW:0] diff;
  logic           qbit;

  always_comb begin
    trial  = {data_i.rem, data_i.dq[DividendW-1]};
    diff   = trial - {1'b0, data_i.div};
    qbit   = (trial >= {1'b0, data_i.div});
    data_d = data_i;
    data_d.rem = qbit ? diff[DataW-1:0] : trial[DataW-1:0];
    data_d.dq  = {data_i.dq[DividendW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/atu_clamp.sv */
module atu_clamp import atu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_data_t        data_i,
  input  limits_t          limits_i,
  output logic             valid_o,
  output logic [DataW-1:0] thr_o
);

  logic             valid_q;
  logic [DataW-1:0] thr_q, thr_d;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] lo_s, hi_s;
  logic signed [SumW-1:0] clamped;

  always_comb begin
    lo_s = $signed({{(SumW-DataW){1'b0}}, limits_i.lower});
    hi_s = $signed({{(SumW-DataW){1'b0}}, limits_i.upper});
    if (data_i.fired) begin
      sum = $signed({{(SumW-DataW){1'b0}}, data_i.thr})
          + $signed({{(SumW-DividendW){1'b0}}, data_i.dq});
    end else begin
      sum = $signed({{(SumW-DataW){1'b0}}, data_i.thr})
          - $signed({{(SumW-DividendW){1'b0}}, data_i.dq});
    end
    clamped = (sum < lo_s) ? lo_s : sum;
    clamped = (clamped > hi_s) ? hi_s : clamped;
    if (data_i.zero) begin
      thr_d = data_i.fired ? limits_i.upper : limits_i.lower;
    end else begin
      thr_d = clamped[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      thr_q <= thr_d;
    end
  end

  assign valid_o = valid_q;
  assign thr_o   = thr_q;

endmodule

/* sv/adaptive_threshold_update.sv */
// Channel | Dir | Signals                          | Content
// s_axis  | in  | tvalid tready tdata[31:0] tuser  | threshold_in, min_distance; fired
// m_axis  | out | tvalid tready tdata[15:0]        | threshold_out
// cfg     | in  | cfg_valid cfg_ready index data   | step and limit registers
//
// One item per cycle while the output is not stalled; 24 restoring divider cells, one quotient
// bit each, then the add/clamp output register.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole chain; s_axis_tready falls in the same cycle.
module adaptive_threshold_update import atu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*DataW-1:0]    s_axis_tdata,   // threshold_in, min_distance
  input  logic                  s_axis_tuser,   // fired
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DataW-1:0]      m_axis_tdata,   // threshold_out
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [DataW-1:0]      cfg_data_i
);

  logic [DataW-1:0] inc_step_q, dec_step_q;
  limits_t          limits_q;
  logic             en;

  logic      valid_c [DividendW+1];
  div_data_t data_c  [DividendW+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_step_q     <= IncreaseStepRst;
      dec_step_q     <= DecreaseStepRst;
      limits_q.upper <= UpperLimitRst;
      limits_q.lower <= LowerLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegIncreaseStep: inc_step_q     <= cfg_data_i;
        RegDecreaseStep: dec_step_q     <= cfg_data_i;
        RegUpperLimit:   limits_q.upper <= cfg_data_i;
        RegLowerLimit:   limits_q.lower <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    valid_c[0]       = s_axis_tvalid;
    data_c[0].thr    = s_axis_tdata[DataW-1:0];
    data_c[0].fired  = s_axis_tuser;
    data_c[0].div    = s_axis_tdata[2*DataW-1:DataW];
    data_c[0].zero   = (s_axis_tdata[2*DataW-1:DataW] == '0);
    data_c[0].rem    = '0;
    data_c[0].dq     = {(s_axis_tuser ? inc_step_q : dec_step_q), {FracW{1'b0}}};
  end

  for (genvar g = 0; g < DividendW; g++) begin : g_cell
    atu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  atu_clamp u_clamp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_c[DividendW]),
    .data_i   (data_c[DividendW]),
    .limits_i (limits_q),
    .valid_o  (m_axis_tvalid),
    .thr_o    (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted during output stall");

  a_out_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (limits_q.lower <= limits_q.upper)) |->
      (m_axis_tdata >= limits_q.lower) && (m_axis_tdata <= limits_q.upper))
    else $error("threshold outside limits");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_c[DividendW] && !data_c[DividendW].zero) |->
      (data_c[DividendW].rem < data_c[DividendW].div))
    else $error("divider remainder not reduced");
`endif

endmodule

/* tb/tb_adaptive_threshold_update.sv */
module tb_adaptive_threshold_update;
  import atu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLatency = 25;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ItemsPerSetting = 190;
  localparam int unsigned RandomSettings  = 6;
  localparam logic [CfgIdxW-1:0] RegUnknownFirst = RegLowerLimit + 1'b1;
  localparam logic [CfgIdxW-1:0] RegUnknownLast  = '1;
  localparam logic [DataW-1:0]   AllOnes = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*DataW-1:0]   s_axis_tdata = '0;   // threshold_in, min_distance
  logic                 s_axis_tuser = 1'b0; // fired
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DataW-1:0]     m_axis_tdata;        // threshold_out
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [DataW-1:0]     cfg_data_i = '0;

  // shadow copy of the step and limit registers
  logic [DataW-1:0] inc_step;
  logic [DataW-1:0] dec_step;
  limits_t          lim;

  logic [DataW-1:0] thr_expected_q[$];
  int unsigned      err_cnt = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      rx_wait = 0;
  bit               tx_idle_en = 1'b0;
  bit               rx_idle_en = 1'b0;

  adaptive_threshold_update uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [DataW-1:0] next_threshold(logic [DataW-1:0] thr, logic fired,
                                                      logic [DataW-1:0] min_dist);
    logic [DividendW-1:0] num;
    logic [DividendW-1:0] step;
    int                   sum;
    if (min_dist == '0) begin
      return fired ? lim.upper : lim.lower;
    end
    num  = {(fired ? inc_step : dec_step), {FracW{1'b0}}};
    step = num / min_dist;
    sum  = fired ? int'(thr) + int'(step) : int'(thr) - int'(step);
    if (sum < int'(lim.lower)) sum = int'(lim.lower);
    if (sum > int'(lim.upper)) sum = int'(lim.upper);
    return sum[DataW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("%0t: %s: got 0x%04h, expected 0x%04h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic check_threshold(logic [DataW-1:0] got);
    logic [DataW-1:0] want;
    if (thr_expected_q.size() == 0) begin
      report_mismatch("unexpected threshold_out", got, '0);
    end else begin
      want = thr_expected_q.pop_front();
      if (got !== want) report_mismatch("threshold_out", got, want);
    end
  endtask

  // result side: check every transaction, then stall for a random wait if rx_idle_en is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tready) begin
        if (m_axis_tvalid) begin
          check_threshold(m_axis_tdata);
          rx_wait = rx_idle_en ? $urandom_range(0, 15) : 0;
          if (rx_wait != 0) m_axis_tready <= 1'b0;
        end
      end else begin
        if (rx_wait > 0) rx_wait--;
        if (rx_wait == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb_adaptive_threshold_update failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered at a rising edge; valid stays high across back-to-back items
  task automatic send_item(logic [DataW-1:0] thr, logic fired, logic [DataW-1:0] min_dist);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {min_dist, thr};
    s_axis_tuser  <= fired;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    thr_expected_q.push_back(next_threshold(thr, fired, min_dist));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (thr_expected_q.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegIncreaseStep: inc_step  = val;
      RegDecreaseStep: dec_step  = val;
      RegUpperLimit:   lim.upper = val;
      RegLowerLimit:   lim.lower = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [DataW-1:0] inc, logic [DataW-1:0] dec,
                         logic [DataW-1:0] upper, logic [DataW-1:0] lower);
    cfg_write(RegIncreaseStep, inc);
    cfg_write(RegDecreaseStep, dec);
    cfg_write(RegUpperLimit, upper);
    cfg_write(RegLowerLimit, lower);
  endtask

  function automatic logic [DataW-1:0] rand_reg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return AllOnes;
      2:       return DataW'($urandom_range(0, 255));
      default: return DataW'($urandom());
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return DataW'($urandom_range(1, 255));
      4:       return AllOnes;
      default: return DataW'($urandom());
    endcase
  endfunction

  task automatic test_reset_values();
    send_item('0, 1'b0, 16'h0001);
    send_item(AllOnes, 1'b1, 16'h0001);
    send_item(AllOnes, 1'b0, AllOnes);
    send_item('0, 1'b1, AllOnes);
    send_item(16'h1234, 1'b0, '0);
    send_item(16'h1234, 1'b1, '0);
    send_item(16'h0400, 1'b1, 16'h0100);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // full-scale registers
    set_all(AllOnes, AllOnes, AllOnes, AllOnes);
    send_item('0, 1'b1, 16'h0001);
    send_item(AllOnes, 1'b0, 16'h0001);
    wait_idle();
    // zero step numerator: clamp only
    set_all('0, '0, 16'hf000, 16'h0100);
    send_item(AllOnes, 1'b1, 16'h0005);
    send_item('0, 1'b0, 16'h0005);
    send_item(16'h5555, 1'b1, 16'h0005);
    wait_idle();
    // quotient floors to zero, and reaches one at the boundary
    set_all(16'h0001, 16'h0001, AllOnes, '0);
    send_item(16'h7fff, 1'b1, AllOnes);
    send_item(16'h7fff, 1'b0, 16'h0101);
    send_item(16'h7fff, 1'b0, 16'h0100);
    wait_idle();
    // lower above upper
    set_all(16'h0100, 16'h0100, 16'h1000, 16'h8000);
    send_item(16'h4000, 1'b1, 16'h0100);
    send_item(16'h4000, 1'b0, 16'h0100);
    send_item(16'h4000, 1'b0, '0);
    send_item(16'h4000, 1'b1, '0);
    wait_idle();
    // unmapped indexes leave the registers alone
    cfg_write(RegUnknownFirst, '0);
    cfg_write(RegUnknownLast, AllOnes);
    send_item(16'h4000, 1'b1, 16'h0100);
    send_item(16'h4000, 1'b0, '0);
    wait_idle();
  endtask

  task automatic test_random_settings();
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    for (int unsigned p = 0; p < RandomSettings; p++) begin
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 3) != 1;
      a = rand_reg();
      b = rand_reg();
      if ($urandom_range(0, 3) != 0 && a < b) begin
        set_all(rand_reg(), rand_reg(), b, a);
      end else begin
        set_all(rand_reg(), rand_reg(), a, b);
      end
      if ($urandom_range(0, 1) != 0) begin
        cfg_write(CfgIdxW'($urandom_range(RegUnknownFirst, RegUnknownLast)), DataW'($urandom()));
      end
      for (int unsigned i = 0; i < ItemsPerSetting; i++) begin
        send_item(DataW'($urandom()), 1'($urandom()), rand_dist());
      end
      wait_idle();
    end
  endtask

  initial begin
    inc_step  = IncreaseStepRst;
    dec_step  = DecreaseStepRst;
    lim.upper = UpperLimitRst;
    lim.lower = LowerLimitRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reset_values();
    test_special_cases();
    test_random_settings();
    repeat (PipeLatency + 5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_adaptive_threshold_update passed");
    end else begin
      $display("tb_adaptive_threshold_update failed");
    end
    $finish;
  end

endmodule
